[design/sub_cpu_bus_decoder_word_ram_gate_core_assert.svh]
// Assertion macros for the sub-CPU bus decoder.
`ifndef SUB_CPU_BUS_DECODER_WORD_RAM_GATE_CORE_ASSERT_SVH
`define SUB_CPU_BUS_DECODER_WORD_RAM_GATE_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SCBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SCBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/scbd_pkg.sv]
// Shared types and constants of the sub-CPU bus decoder.
`timescale 1ns / 1ps
package scbd_pkg;
    localparam int IRQ_LINES_DEF   = 6;
    localparam int TIMER_SCALE_DEF = 1536;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MAIN  = 2'd2,
        OP_GRANT = 2'd3
    } op_t;

    // Decoded target of a transaction.
    typedef enum logic [3:0] {
        TG_NONE, TG_PRG, TG_WRAM, TG_MODE, TG_FLAG, TG_CMD, TG_STAT,
        TG_TIMER, TG_MASK, TG_TRACE, TG_MFLAG, TG_MCMD, TG_GRANT
    } target_t;

    typedef struct packed {
        op_t         op;
        target_t     target;
        logic        refused;
        logic [17:0] index;
        logic [15:0] data;
        logic        hi;
        logic        lo;
    } cmd_t;
endpackage

[design/scbd_front.sv]
// Front end: decode and classify each bus transaction.
`timescale 1ns / 1ps
module scbd_front (
    input  logic [1:0]   op,
    input  logic [22:0]  word_address,
    input  logic [15:0]  write_data,
    input  logic         high_byte_enable,
    input  logic         low_byte_enable,
    input  logic [7:0]   prg_write_protect,
    input  logic         one_meg,
    input  logic         owns,
    input  logic         ret,
    output scbd_pkg::cmd_t cmd
);
    logic [23:0] addr;
    logic [17:0] prot_words;
    assign addr = {word_address, 1'b0};
    assign prot_words = {prg_write_protect, 8'd0} + 18'd0;

    always_comb
    begin
        cmd.op      = scbd_pkg::op_t'(op);
        cmd.data    = write_data;
        cmd.hi      = high_byte_enable;
        cmd.lo      = low_byte_enable;
        cmd.index   = word_address[17:0];
        cmd.refused = 1'b0;
        cmd.target  = scbd_pkg::TG_NONE;
        unique case (scbd_pkg::op_t'(op))
            scbd_pkg::OP_GRANT: cmd.target = scbd_pkg::TG_GRANT;
            scbd_pkg::OP_MAIN:
            begin
                cmd.index = {15'd0, word_address[2:0] - 3'd1};
                if (word_address == 23'd0)
                    cmd.target = scbd_pkg::TG_MFLAG;
                else if (word_address <= 23'd8)
                    cmd.target = scbd_pkg::TG_MCMD;
                else
                    cmd.refused = 1'b1;
            end
            default:
            begin
                if (addr < 24'h080000)
                begin
                    cmd.target = scbd_pkg::TG_PRG;
                    if (op == scbd_pkg::OP_WRITE && word_address[17:0] < prot_words)
                        cmd.refused = 1'b1;
                end
                else if (addr < 24'h0C0000)
                begin
                    cmd.target = scbd_pkg::TG_WRAM;
                    cmd.index  = {1'b0, word_address[16:0]};
                    cmd.refused = one_meg || !owns;
                end
                else if (addr < 24'h0E0000)
                begin
                    cmd.target = scbd_pkg::TG_WRAM;
                    cmd.index  = {1'b0, word_address[15:0], ~ret};
                    cmd.refused = !one_meg;
                end
                else if (addr == 24'hFF8002) cmd.target = scbd_pkg::TG_MODE;
                else if (addr == 24'hFF800E) cmd.target = scbd_pkg::TG_FLAG;
                else if (addr >= 24'hFF8010 && addr < 24'hFF8020)
                begin
                    cmd.target = scbd_pkg::TG_CMD;
                    cmd.refused = (op == scbd_pkg::OP_WRITE);
                end
                else if (addr >= 24'hFF8020 && addr < 24'hFF8030)
                    cmd.target = scbd_pkg::TG_STAT;
                else if (addr == 24'hFF8030)
                begin
                    cmd.target = scbd_pkg::TG_TIMER;
                    cmd.refused = (op == scbd_pkg::OP_READ);
                end
                else if (addr == 24'hFF8032) cmd.target = scbd_pkg::TG_MASK;
                else if (addr == 24'hFF8066) cmd.target = scbd_pkg::TG_TRACE;
                else cmd.refused = 1'b1;
                if (cmd.target == scbd_pkg::TG_FLAG && op == scbd_pkg::OP_WRITE)
                    cmd.refused = high_byte_enable;
            end
        endcase
    end
endmodule

[design/scbd_queue.sv]
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module scbd_queue #(
    parameter int DEPTH = scbd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scbd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           empty,
    output logic           full,
    output scbd_pkg::cmd_t head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    scbd_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0] rd_reg, wr_reg;
    logic [AW:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

[design/scbd_back.sv]
// Back end: execute transactions against RAMs and registers.
`timescale 1ns / 1ps
module scbd_back #(
    parameter int IRQ_LINES   = scbd_pkg::IRQ_LINES_DEF,
    parameter int TIMER_SCALE = scbd_pkg::TIMER_SCALE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  scbd_pkg::cmd_t cmd,
    output logic           q_pop,
    input  logic [7:0]     prg_write_protect,
    output logic           one_meg,
    output logic           owns,
    output logic           ret,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [15:0]    read_data,
    output logic           access_refused,
    output logic [5:0]     irq_enable_mask,
    output logic           irq1_pending_out,
    output logic [19:0]    timer_period
);
    localparam logic [19:0] TIMER_MAX = 20'hFFFFF;
    logic [15:0] prg_ram [262144];
    logic [15:0] wram [131072];
    logic [15:0] flag_reg, flag_next;
    logic [15:0] cmds_reg [8];
    logic [15:0] stat_reg [8];
    logic        om_reg, om_next, own_reg, own_next, ret_reg, ret_next;
    logic [5:0]  ien_reg, ien_next;
    logic        pend_reg, pend_next;
    logic [19:0] tim_reg, tim_next;
    logic [15:0] mask, rd_next, ram_q_reg, rd_reg;
    logic        ref_reg, ovld_reg, busy_reg;
    logic [28:0] prod_reg;
    logic [15:0] wdata;
    logic [2:0]  ci;
    logic        fire, ram_wr, ram_rd;
    scbd_pkg::cmd_t c;
    assign c = cmd;
    assign ci = c.index[2:0];
    assign mask = {{8{c.hi}}, {8{c.lo}}};

    // Read-modify-write is split into a RAM read, then a merge and write.
    // busy_reg marks the merge/write step of the head item; a stalled result holds it there.
    assign q_pop = !q_empty && busy_reg && (!ovld_reg || !out_stall);
    assign fire  = q_pop;
    assign ram_wr = fire && !c.refused && c.op == scbd_pkg::OP_WRITE &&
                    (c.target == scbd_pkg::TG_PRG || c.target == scbd_pkg::TG_WRAM);
    assign ram_rd = !c.refused && c.op == scbd_pkg::OP_READ &&
                    (c.target == scbd_pkg::TG_PRG || c.target == scbd_pkg::TG_WRAM);
    assign wdata = (ram_q_reg & ~mask) | (c.data & mask);

    always_ff @(posedge clk)
    begin
        if (!q_empty && !busy_reg)
        begin
            if (c.target == scbd_pkg::TG_PRG) ram_q_reg <= prg_ram[c.index];
            else ram_q_reg <= wram[c.index[16:0]];
        end
        if (ram_wr && c.target == scbd_pkg::TG_PRG) prg_ram[c.index] <= wdata;
        if (ram_wr && c.target == scbd_pkg::TG_WRAM) wram[c.index[16:0]] <= wdata;
    end

    always_comb
    begin
        flag_next = flag_reg; om_next = om_reg; own_next = own_reg; ret_next = ret_reg;
        ien_next = ien_reg; pend_next = pend_reg; tim_next = tim_reg; rd_next = '0;
        // A flag write with the high lane is refused but still writes the low lane.
        if (!c.refused || c.target == scbd_pkg::TG_FLAG)
        begin
            unique case (c.target)
                scbd_pkg::TG_GRANT: own_next = 1'b1;
                scbd_pkg::TG_MFLAG: if (c.hi) flag_next[15:8] = c.data[15:8];
                scbd_pkg::TG_MODE:
                    if (c.op == scbd_pkg::OP_READ)
                        rd_next = {prg_write_protect, 5'd0, om_reg, own_reg, ret_reg};
                    else if (c.lo)
                    begin
                        om_next = c.data[2];
                        if (c.data[0] || c.data[2])
                        begin
                            own_next = 1'b0;
                            ret_next = c.data[0];
                        end
                    end
                scbd_pkg::TG_FLAG:
                    if (c.op == scbd_pkg::OP_READ) rd_next = flag_reg;
                    else if (c.lo) flag_next[7:0] = c.data[7:0];
                scbd_pkg::TG_CMD: rd_next = cmds_reg[ci];
                scbd_pkg::TG_STAT: if (c.op == scbd_pkg::OP_READ) rd_next = stat_reg[ci];
                scbd_pkg::TG_TIMER:
                    if (c.lo)
                        tim_next = (c.data[7:0] == 8'd0) ? '0 :
                                   (prod_reg > 29'(TIMER_MAX)) ? TIMER_MAX : prod_reg[19:0];
                scbd_pkg::TG_MASK:
                    if (c.op == scbd_pkg::OP_READ) rd_next = {9'd0, ien_reg, 1'b0};
                    else if (c.lo)
                    begin
                        ien_next = c.data[6:1] & 6'((1 << IRQ_LINES) - 1);
                        if (!ien_next[0]) pend_next = 1'b0;
                    end
                scbd_pkg::TG_TRACE:
                    if (c.op == scbd_pkg::OP_WRITE && ien_reg[0]) pend_next = 1'b1;
                scbd_pkg::TG_PRG, scbd_pkg::TG_WRAM: rd_next = '0;
                default: rd_next = '0;
            endcase
        end
    end

    // Capture the result word at pop so a stalled result never changes.
    always_ff @(posedge clk)
    begin
        prod_reg <= 29'({21'd0, c.data[7:0]} + 29'd1) * 29'(TIMER_SCALE);
        if (fire)
        begin
            rd_reg <= ram_rd ? ram_q_reg : rd_next;
            ref_reg <= c.refused;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0; om_reg <= 1'b0; own_reg <= 1'b0; ret_reg <= 1'b0;
            ien_reg <= '0; pend_reg <= 1'b0; tim_reg <= '0;
            ovld_reg <= 1'b0; busy_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cmds_reg[i] <= '0;
                stat_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                flag_reg <= flag_next; om_reg <= om_next; own_reg <= own_next;
                ret_reg <= ret_next; ien_reg <= ien_next; pend_reg <= pend_next;
                tim_reg <= tim_next;
            end
            if (fire && c.op == scbd_pkg::OP_MAIN && c.target == scbd_pkg::TG_MCMD)
                cmds_reg[ci] <= (cmds_reg[ci] & ~mask) | (c.data & mask);
            if (fire && !c.refused && c.op == scbd_pkg::OP_WRITE &&
                c.target == scbd_pkg::TG_STAT)
                stat_reg[ci] <= (stat_reg[ci] & ~mask) | (c.data & mask);
            if (fire) busy_reg <= 1'b0;
            else if (!q_empty) busy_reg <= 1'b1;
            if (fire) ovld_reg <= 1'b1;
            else if (!out_stall) ovld_reg <= 1'b0;
        end
    end

    assign out_valid        = ovld_reg;
    assign read_data        = rd_reg;
    assign access_refused   = ref_reg;
    assign irq_enable_mask  = ien_reg;
    assign irq1_pending_out = pend_reg;
    assign timer_period     = tim_reg;
    assign one_meg = om_reg;
    assign owns    = own_reg;
    assign ret     = ret_reg;
endmodule

[design/sub_cpu_bus_decoder_word_ram_gate_core.sv]
// Top level of the sub-CPU bus decoder with word RAM gating.
//  channel  | handshake               | payload
//  in       | in_valid / in_stall     | op, word_address, write_data, byte enables
//  out      | out_valid / out_stall   | read_data, access_refused, irq/timer state
//  cfg      | cfg_write_enable        | cfg_write_data (write protect)
// Word RAM decode uses mode bits as left by prior items, so the front admits a
// transaction only while the queue and back end are empty. The back end takes each
// through a RAM read, then merge/write and result, an order set by the single RAM port.
// A new transaction is admitted only once the previous one has left the queue.
// A stalled result holds the back end and so the input. Reset clears the state and
// handshake registers; RAM contents, queue entries and the result word stay undefined.
`timescale 1ns / 1ps
module sub_cpu_bus_decoder_word_ram_gate_core #(
    parameter int IRQ_LINES   = scbd_pkg::IRQ_LINES_DEF,
    parameter int TIMER_SCALE = scbd_pkg::TIMER_SCALE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [22:0] word_address,
    input  logic [15:0] write_data,
    input  logic        high_byte_enable,
    input  logic        low_byte_enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        access_refused,
    output logic [5:0]  irq_enable_mask,
    output logic        irq1_pending_out,
    output logic [19:0] timer_period
);
    logic [7:0] wp_reg;
    logic one_meg, owns, ret, q_empty, q_full, q_pop, push;
    scbd_pkg::cmd_t fcmd, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) wp_reg <= '0;
        else if (cfg_write_enable) wp_reg <= cfg_write_data;
    end

    // Hold new transactions until the previous one has updated the mode bits.
    assign in_stall = !q_empty || q_full;
    assign push = in_valid && !in_stall;

    scbd_front u_front (
        .op(op), .word_address(word_address), .write_data(write_data),
        .high_byte_enable(high_byte_enable), .low_byte_enable(low_byte_enable),
        .prg_write_protect(wp_reg), .one_meg(one_meg), .owns(owns), .ret(ret),
        .cmd(fcmd)
    );

    scbd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(fcmd), .pop(q_pop),
        .empty(q_empty), .full(q_full), .head(head)
    );

    scbd_back #(.IRQ_LINES(IRQ_LINES), .TIMER_SCALE(TIMER_SCALE)) u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .cmd(head), .q_pop(q_pop),
        .prg_write_protect(wp_reg), .one_meg(one_meg), .owns(owns), .ret(ret),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
        .access_refused(access_refused), .irq_enable_mask(irq_enable_mask),
        .irq1_pending_out(irq1_pending_out), .timer_period(timer_period)
    );
endmodule

[design/scbd_checker.sv]
// Port-level checker for the sub-CPU bus decoder.
`timescale 1ns / 1ps
`include "sub_cpu_bus_decoder_word_ram_gate_core_assert.svh"
module scbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] read_data,
    input logic        access_refused
);
    `SCBD_ASSERT_IMP(a_refused_zero, clk, rst_n, out_valid && access_refused, read_data == 16'd0)
    `SCBD_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
    `SCBD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_data))
endmodule

bind sub_cpu_bus_decoder_word_ram_gate_core scbd_checker u_scbd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
    .access_refused(access_refused)
);

[tb/sub_cpu_bus_decoder_word_ram_gate_core_checker.sv]
// Bus decoder predictor and result checker.
`timescale 1ns / 1ps
module sub_cpu_bus_decoder_word_ram_gate_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [22:0] word_address,
    input  logic [15:0] write_data,
    input  logic        high_byte_enable,
    input  logic        low_byte_enable,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] read_data,
    input  logic        access_refused,
    input  logic [5:0]  irq_enable_mask,
    input  logic        irq1_pending_out,
    input  logic [19:0] timer_period,
    output int          failures,
    output int          pending,
    output int          seen
);
    typedef struct packed {
        logic [15:0] rd;
        logic        refused;
        logic [5:0]  irq_en;
        logic        irq1;
        logic [19:0] timer;
    } bus_reply_t;

    bus_reply_t  replies[$];
    logic [15:0] prg_mem[int];
    logic [15:0] wram_mem[int];
    logic [7:0]  protect;
    logic        mode_1m, owns, ret_bank, l1_pending;
    logic [15:0] flag_word;
    logic [15:0] cmd_words[8];
    logic [15:0] stat_words[8];
    logic [5:0]  irq_en;
    logic [19:0] timer_reg;

    function automatic logic [15:0] lane_merge(logic [15:0] old, logic [15:0] val,
                                               logic [15:0] m);
        return (old & ~m) | (val & m);
    endfunction

    task automatic decode_access(input scbd_pkg::op_t o, input logic [22:0] wa,
                                 input logic [15:0] d, input logic hi, input logic lo);
        bus_reply_t  r;
        logic [23:0] a;
        logic [15:0] m;
        int          idx;
        int          b;
        int          p;
        a = {wa, 1'b0};
        m = {{8{hi}}, {8{lo}}};
        r = '0;
        case (o)
            scbd_pkg::OP_GRANT: owns = 1'b1;
            scbd_pkg::OP_MAIN:
                if (wa == 0) begin
                    if (hi) flag_word[15:8] = d[15:8];
                end else if (wa <= 8) cmd_words[wa - 1] = lane_merge(cmd_words[wa - 1], d, m);
                else r.refused = 1'b1;
            scbd_pkg::OP_READ:
                if (a < 24'h80000) r.rd = prg_mem.exists(wa) ? prg_mem[wa] : 16'h0;
                else if (a < 24'hC0000) begin
                    idx = wa & 23'h1FFFF;
                    if (mode_1m || !owns) r.refused = 1'b1;
                    else r.rd = wram_mem.exists(idx) ? wram_mem[idx] : 16'h0;
                end else if (a < 24'hE0000) begin
                    idx = (wa & 23'hFFFF) * 2 + (ret_bank ? 0 : 1);
                    if (!mode_1m) r.refused = 1'b1;
                    else r.rd = wram_mem.exists(idx) ? wram_mem[idx] : 16'h0;
                end else if (a == 24'hFF8002) r.rd = {protect, 5'd0, mode_1m, owns, ret_bank};
                else if (a == 24'hFF800E) r.rd = flag_word;
                else if (a >= 24'hFF8010 && a < 24'hFF8020) r.rd = cmd_words[a[3:1]];
                else if (a >= 24'hFF8020 && a < 24'hFF8030) r.rd = stat_words[a[3:1]];
                else if (a == 24'hFF8032) r.rd = {9'd0, irq_en, 1'b0};
                else if (a != 24'hFF8066) r.refused = 1'b1;
            default:
                if (a < 24'h80000) begin
                    if (a < protect * 32'h200) r.refused = 1'b1;
                    else prg_mem[wa] = lane_merge(prg_mem.exists(wa) ? prg_mem[wa] : 16'h0, d, m);
                end else if (a < 24'hE0000) begin
                    if (a < 24'hC0000) begin
                        idx = wa & 23'h1FFFF;
                        r.refused = mode_1m || !owns;
                    end else begin
                        idx = (wa & 23'hFFFF) * 2 + (ret_bank ? 0 : 1);
                        r.refused = !mode_1m;
                    end
                    if (!r.refused)
                        wram_mem[idx] = lane_merge(wram_mem.exists(idx) ? wram_mem[idx] : 16'h0,
                                                   d, m);
                end else if (a == 24'hFF8002) begin
                    if (lo) begin
                        mode_1m = d[2];
                        if (d[0] || mode_1m) begin
                            owns = 1'b0;
                            ret_bank = d[0];
                        end
                    end
                end else if (a == 24'hFF800E) begin
                    r.refused = hi;
                    if (lo) flag_word[7:0] = d[7:0];
                end else if (a >= 24'hFF8010 && a < 24'hFF8020) r.refused = 1'b1;
                else if (a >= 24'hFF8020 && a < 24'hFF8030)
                    stat_words[a[3:1]] = lane_merge(stat_words[a[3:1]], d, m);
                else if (a == 24'hFF8030) begin
                    if (lo) begin
                        b = d[7:0];
                        p = (b == 0) ? 0 : (b + 1) * scbd_pkg::TIMER_SCALE_DEF;
                        timer_reg = (p > 'hFFFFF) ? 20'hFFFFF : p[19:0];
                    end
                end else if (a == 24'hFF8032) begin
                    if (lo) begin
                        irq_en = d[6:1] & 6'((1 << scbd_pkg::IRQ_LINES_DEF) - 1);
                        if (!irq_en[0]) l1_pending = 1'b0;
                    end
                end else if (a == 24'hFF8066) begin
                    if (irq_en[0]) l1_pending = 1'b1;
                end else r.refused = 1'b1;
        endcase
        if (r.refused) r.rd = '0;
        r.irq_en = irq_en;
        r.irq1 = l1_pending;
        r.timer = timer_reg;
        replies.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_reply_t e;
        if (!rst_n)
        begin
            replies.delete();
            protect = '0; mode_1m = 0; owns = 0; ret_bank = 0; l1_pending = 0;
            flag_word = '0; irq_en = '0; timer_reg = '0;
            foreach (cmd_words[i]) cmd_words[i] = '0;
            foreach (stat_words[i]) stat_words[i] = '0;
            failures = 0;
            seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write_enable) protect = cfg_write_data;
            if (in_valid && !in_stall)
                decode_access(scbd_pkg::op_t'(op), word_address, write_data,
                              high_byte_enable, low_byte_enable);
            if (out_valid && !out_stall)
            begin
                seen++;
                if (replies.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    failures++;
                end
                else
                begin
                    e = replies.pop_front();
                    if (read_data !== e.rd)
                    begin
                        $error("read_data exp %h got %h", e.rd, read_data); failures++;
                    end
                    if (access_refused !== e.refused)
                    begin
                        $error("access_refused exp %b got %b", e.refused, access_refused);
                        failures++;
                    end
                    if (irq_enable_mask !== e.irq_en)
                    begin
                        $error("irq_enable_mask exp %h got %h", e.irq_en, irq_enable_mask);
                        failures++;
                    end
                    if (irq1_pending_out !== e.irq1)
                    begin
                        $error("irq1_pending_out exp %b got %b", e.irq1, irq1_pending_out);
                        failures++;
                    end
                    if (timer_period !== e.timer)
                    begin
                        $error("timer_period exp %h got %h", e.timer, timer_period);
                        failures++;
                    end
                end
            end
            pending = replies.size();
        end
    end
endmodule

[tb/sub_cpu_bus_decoder_word_ram_gate_core_test.sv]
// Testbench top: clock, reset, stimulus and verdict for the bus decoder.
`timescale 1ns / 1ps
module sub_cpu_bus_decoder_word_ram_gate_core_test;
    logic        clk, rst_n;
    logic        cfg_write_enable;
    logic [7:0]  cfg_write_data;
    logic        in_valid, in_stall;
    logic [1:0]  op;
    logic [22:0] word_address;
    logic [15:0] write_data;
    logic        high_byte_enable, low_byte_enable;
    logic        out_valid, out_stall;
    logic [15:0] read_data;
    logic        access_refused;
    logic [5:0]  irq_enable_mask;
    logic        irq1_pending_out;
    logic [19:0] timer_period;
    int          failures, pending, seen;
    int          sent;

    // Word addresses of the register block (byte address / 2).
    localparam logic [22:0] WA_MODE  = 23'h7FC001;
    localparam logic [22:0] WA_FLAG  = 23'h7FC007;
    localparam logic [22:0] WA_CMD   = 23'h7FC008;
    localparam logic [22:0] WA_STAT  = 23'h7FC010;
    localparam logic [22:0] WA_TIMER = 23'h7FC018;
    localparam logic [22:0] WA_MASK  = 23'h7FC019;
    localparam logic [22:0] WA_TRACE = 23'h7FC033;

    // Track which RAM words were written so reads never hit undefined contents.
    // Keys: PRG word address, or shared RAM index offset by 1<<20.
    bit          written[int];
    logic [7:0]  wp_shadow;
    logic        m1_shadow, own_shadow, ret_shadow;

    sub_cpu_bus_decoder_word_ram_gate_core i_dut (.*);
    sub_cpu_bus_decoder_word_ram_gate_core_checker i_check (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, mostly short with occasional long ones.
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
            else
                repeat ($urandom_range(0, 20)) @(posedge clk);
        end
    end

    // Map a bus access to the shadow key of the RAM word it touches, or -1.
    function automatic int ram_key(logic [1:0] o, logic [22:0] wa);
        logic [23:0] a;
        a = {wa, 1'b0};
        if (o > 1) return -1;
        if (a < 24'h80000) return wa;
        if (a < 24'hC0000) return (!m1_shadow && own_shadow) ? (1 << 20) + (wa & 'h1FFFF) : -1;
        if (a < 24'hE0000)
            return m1_shadow ? (1 << 20) + (wa & 'hFFFF) * 2 + (ret_shadow ? 0 : 1) : -1;
        return -1;
    endfunction

    // Send one transaction; a RAM read of an unwritten word becomes a full write.
    // Valid stays high after acceptance until the next call or drain() drops it or replaces the payload.
    task automatic send(logic [1:0] o, logic [22:0] wa, logic [15:0] d, logic hi, logic lo);
        int k;
        k = ram_key(o, wa);
        if (k >= 0 && o == scbd_pkg::OP_READ && !written.exists(k))
        begin
            o = scbd_pkg::OP_WRITE; hi = 1; lo = 1;
        end
        if (k >= 0 && o == scbd_pkg::OP_WRITE && hi && lo &&
            !(k < (1 << 20) && {wa, 1'b0} < wp_shadow * 512))
            written[k] = 1;
        if (o == scbd_pkg::OP_GRANT) own_shadow = 1;
        if (o == scbd_pkg::OP_WRITE && wa == WA_MODE && lo)
        begin
            m1_shadow = d[2];
            if (d[0] || d[2])
            begin
                own_shadow = 0; ret_shadow = d[0];
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat (($urandom_range(0, 19) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2))
                @(posedge clk);
        end
        in_valid <= 1;
        op <= o; word_address <= wa; write_data <= d;
        high_byte_enable <= hi; low_byte_enable <= lo;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Drain, then write the protect register while the block is idle.
    task automatic set_protect(logic [7:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1; cfg_write_data <= v;
        @(posedge clk);
        cfg_write_enable <= 0;
        wp_shadow = v;
    endtask

    function automatic logic [22:0] random_address();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 'h3FFFF);
            3, 4:    return 'h40000 + $urandom_range(0, 'h1FFFF);
            5, 6:    return 'h60000 + $urandom_range(0, 'hFFFF);
            7, 8:    return 23'h7FC000 + $urandom_range(0, 'h3F);
            default: return $urandom_range(0, 'h7FFFFF);
        endcase
    endfunction

    initial
    begin
        int          t;
        logic [1:0]  o;
        logic [22:0] wa;
        rst_n = 0; in_valid = 0; cfg_write_enable = 0; cfg_write_data = 0;
        op = 0; word_address = 0; write_data = 0;
        high_byte_enable = 0; low_byte_enable = 0;
        sent = 0; wp_shadow = 0; m1_shadow = 0; own_shadow = 0; ret_shadow = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: every register, protection edge, mode switch and grant.
        set_protect(8'h02);
        send(scbd_pkg::OP_WRITE, 23'h0, 16'hFFFF, 1, 1);
        send(scbd_pkg::OP_WRITE, 23'h200, 16'h1234, 1, 1);
        send(scbd_pkg::OP_READ, 23'h200, 0, 1, 1);
        send(scbd_pkg::OP_READ, WA_MODE, 0, 1, 1);
        send(scbd_pkg::OP_WRITE, 23'h40000, 16'hAAAA, 1, 1);
        send(scbd_pkg::OP_GRANT, 0, 0, 0, 0);
        send(scbd_pkg::OP_WRITE, 23'h5FFFF, 16'h5555, 1, 1);
        send(scbd_pkg::OP_READ, 23'h5FFFF, 0, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_MODE, 16'h0005, 0, 1);
        send(scbd_pkg::OP_WRITE, 23'h6FFFF, 16'hBEEF, 1, 1);
        send(scbd_pkg::OP_READ, 23'h6FFFF, 0, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_FLAG, 16'hFF3C, 1, 1);
        send(scbd_pkg::OP_MAIN, 23'h0, 16'hA500, 1, 0);
        send(scbd_pkg::OP_READ, WA_FLAG, 0, 1, 1);
        send(scbd_pkg::OP_MAIN, 23'h8, 16'hFFFF, 1, 0);
        send(scbd_pkg::OP_MAIN, 23'h9, 16'hFFFF, 1, 1);
        send(scbd_pkg::OP_READ, WA_CMD + 7, 0, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_CMD, 16'h1, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_STAT + 7, 16'hC3C3, 0, 1);
        send(scbd_pkg::OP_WRITE, WA_TIMER, 16'h00FF, 1, 1);
        send(scbd_pkg::OP_READ, WA_TIMER, 0, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_MASK, 16'hFFFF, 1, 1);
        send(scbd_pkg::OP_WRITE, WA_TRACE, 0, 0, 0);
        send(scbd_pkg::OP_WRITE, WA_MASK, 16'h0000, 0, 1);
        send(scbd_pkg::OP_READ, 23'h7FFFFF, 0, 1, 1);
        set_protect(8'hFF);

        // Random phases, each opened by a protect write: 00, then random values, then FF.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_protect(8'h00);
                5: set_protect(8'hFF);
                default: set_protect($urandom_range(0, 255));
            endcase
            for (int i = 0; i < 200; i++)
            begin
                t = $urandom_range(0, 99);
                o = (t < 45) ? scbd_pkg::OP_READ : (t < 90) ? scbd_pkg::OP_WRITE :
                    (t < 96) ? scbd_pkg::OP_MAIN : scbd_pkg::OP_GRANT;
                wa = (o == scbd_pkg::OP_MAIN) ? $urandom_range(0, 11) : random_address();
                if (o == scbd_pkg::OP_WRITE && $urandom_range(0, 15) == 0) wa = WA_MODE;
                send(o, wa, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
                if (i == 100 && ph == 2)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d transactions over several protect settings; %0d results checked.",
                 sent, seen);
        $display("Covered PRG protection, 1M/2M word RAM, comm, timer and interrupt registers.");
        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

[sub_cpu_bus_decoder_word_ram_gate_core.f]
+incdir+design
design/scbd_pkg.sv
design/scbd_front.sv
design/scbd_queue.sv
design/scbd_back.sv
design/sub_cpu_bus_decoder_word_ram_gate_core.sv
design/scbd_checker.sv
tb/sub_cpu_bus_decoder_word_ram_gate_core_checker.sv
tb/sub_cpu_bus_decoder_word_ram_gate_core_test.sv
